>>> rtl/dssq_pkg.sv
// Shared constants and result kinds for the deadline sorted sleep queue.
`default_nettype none

package dssq_pkg;

    // Default queue geometry
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 6;

    // Fixed field widths
    localparam int DUR_WIDTH  = 32;
    localparam int TIME_WIDTH = 64;
    localparam int KIND_WIDTH = 3;

    // Request opcodes
    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Result kinds
    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_ACCEPT  = 3'd0,
        KIND_IGNORED = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_WOKEN   = 3'd3,
        KIND_NONE    = 3'd4
    } kind_t;

endpackage

`default_nettype wire

>>> rtl/dssq_store.sv
// Entry store of the sleep queue: wake times and ids, one write and one registered read port.
`default_nettype none

module dssq_store
    import dssq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF,
    localparam int IW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [IW-1:0]         wr_addr,
    input  wire logic [TIME_WIDTH-1:0] wr_time,
    input  wire logic [ID_WIDTH-1:0]   wr_id,
    input  wire logic                  rd_en,
    input  wire logic [IW-1:0]         rd_addr,
    output logic      [TIME_WIDTH-1:0] rd_time,
    output logic      [ID_WIDTH-1:0]   rd_id
);

    logic [TIME_WIDTH-1:0] time_mem [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]   id_mem   [QUEUE_DEPTH];

    // Write one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_mem[wr_addr] <= wr_time;
            id_mem[wr_addr]   <= wr_id;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_time <= time_mem[rd_addr];
            rd_id   <= id_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/deadline_sorted_sleep_queue.sv
// Top level of the deadline sorted sleep queue: sequencer, tick counter and result register.
//
// Usage: one input stream (s_*) carries requests, one output stream (m_*) carries
// results. s_tuser is the opcode (0 sleep, 1 tick); s_tdata holds the thread id
// and the signed 32-bit duration. Each result carries its kind in m_tuser, the
// woken id and the tick counter in m_tdata, and m_tlast on the final result of
// a request.
// Entries live in a circular store ordered by wake time. A sleep walks from the
// tail toward the head, moving each entry that wakes at or after the new one up
// one place; each moved entry passes through the single read port and the
// shared 64-bit comparator. An ignored or rejected sleep goes straight to its
// result. A tick reads and compares the head once per woken entry, and once
// more unless the queue empties; each woken entry leaves the head of the store,
// so draining costs no data movement.
// s_tready is high only while the sequencer is idle; one request is worked at a
// time. A finished result waits in the output register while the sequencer
// keeps working; when the receiver stalls with a result pending, the sequencer
// holds until the register frees.
// Reset (aresetn low, synchronous) empties the queue and clears the counter.
`default_nettype none

module deadline_sorted_sleep_queue
    import dssq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF,
    localparam int S_DW       = ((ID_WIDTH + DUR_WIDTH + 7) / 8) * 8,
    localparam int M_DW       = ((ID_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DW-1:0]       s_tdata,   // sleeper_id, sleep_duration
    input  wire logic                  s_tuser,   // opcode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DW-1:0]       m_tdata,   // woken_id, current_time
    output logic      [KIND_WIDTH-1:0] m_tuser,   // kind
    output logic                       m_tlast
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRD,
        ST_SCMP,
        ST_TRD,
        ST_TCMP,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [ID_WIDTH-1:0]   id_reg, id_next;
    logic [TIME_WIDTH-1:0] wake_reg, wake_next;
    logic [TIME_WIDTH-1:0] tick_reg, tick_next;
    logic [CW-1:0]         occ_reg, occ_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [IW-1:0]         pos_reg, pos_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [ID_WIDTH-1:0]   pend_id_reg, pend_id_next;
    kind_t                 res_kind_reg, res_kind_next;
    logic [ID_WIDTH-1:0]   res_id_reg, res_id_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    kind_t                 m_kind_reg, m_kind_next;
    logic [ID_WIDTH-1:0]   m_id_reg, m_id_next;
    logic [TIME_WIDTH-1:0] m_time_reg, m_time_next;
    logic                  m_last_reg, m_last_next;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [TIME_WIDTH-1:0] wr_time;
    logic [ID_WIDTH-1:0]   wr_id;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [TIME_WIDTH-1:0] rd_time;
    logic [ID_WIDTH-1:0]   rd_id;

    logic [TIME_WIDTH-1:0] cmp_a, cmp_b;
    logic                  cmp_lt;
    logic                  out_free;
    logic [ID_WIDTH-1:0]   s_id;
    logic [DUR_WIDTH-1:0]  s_dur;

    // Map a queue position to a store address
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [IW-1:0] l);
        logic [IW:0] sum;
        sum = {1'b0, head} + {1'b0, l};
        if (sum >= (IW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (IW+1)'(QUEUE_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    dssq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_time (wr_time),
        .wr_id   (wr_id),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_time (rd_time),
        .rd_id   (rd_id)
    );

    assign s_id  = s_tdata[ID_WIDTH-1:0];
    assign s_dur = s_tdata[ID_WIDTH +: DUR_WIDTH];

    // Shared comparator: tick path asks tick < wake, sleep path asks stored < new
    always_comb begin
        if (state_reg == ST_TCMP) begin
            cmp_a = tick_reg;
            cmp_b = rd_time;
        end else begin
            cmp_a = rd_time;
            cmp_b = wake_reg;
        end
    end
    assign cmp_lt = cmp_a < cmp_b;

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        id_next         = id_reg;
        wake_next       = wake_reg;
        tick_next       = tick_reg;
        occ_next        = occ_reg;
        head_next       = head_reg;
        pos_next        = pos_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        res_kind_next   = res_kind_reg;
        res_id_next     = res_id_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_kind_next     = m_kind_reg;
        m_id_next       = m_id_reg;
        m_time_next     = m_time_reg;
        m_last_next     = m_last_reg;

        wr_en   = 1'b0;
        wr_addr = phys(head_reg, pos_reg);
        wr_time = rd_time;
        wr_id   = rd_id;
        rd_en   = 1'b0;
        rd_addr = phys(head_reg, pos_reg - IW'(1));

        // Drop a result the receiver took
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    id_next = s_id;
                    if (s_tuser == OP_TICK) begin
                        tick_next       = tick_reg + TIME_WIDTH'(1);
                        pend_valid_next = 1'b0;
                        state_next      = ST_TRD;
                    end else if (s_dur == '0 || s_dur[DUR_WIDTH-1]) begin
                        res_kind_next = KIND_IGNORED;
                        res_id_next   = '0;
                        state_next    = ST_EMIT;
                    end else if (occ_reg == CW'(QUEUE_DEPTH)) begin
                        res_kind_next = KIND_FULL;
                        res_id_next   = '0;
                        state_next    = ST_EMIT;
                    end else begin
                        wake_next  = tick_reg + TIME_WIDTH'(s_dur);
                        pos_next   = occ_reg[IW-1:0];
                        state_next = ST_SRD;
                    end
                end
            end
            ST_SRD: begin
                if (pos_reg == '0) begin
                    // Reached the head: place the new entry
                    wr_en         = 1'b1;
                    wr_time       = wake_reg;
                    wr_id         = id_reg;
                    occ_next      = occ_reg + CW'(1);
                    res_kind_next = KIND_ACCEPT;
                    res_id_next   = '0;
                    state_next    = ST_EMIT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP: begin
                if (!cmp_lt) begin
                    // Stored entry wakes no earlier: move it up one place
                    wr_en      = 1'b1;
                    pos_next   = pos_reg - IW'(1);
                    state_next = ST_SRD;
                end else begin
                    wr_en         = 1'b1;
                    wr_time       = wake_reg;
                    wr_id         = id_reg;
                    occ_next      = occ_reg + CW'(1);
                    res_kind_next = KIND_ACCEPT;
                    res_id_next   = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_TRD: begin
                if (occ_reg == '0) begin
                    res_kind_next = pend_valid_reg ? KIND_WOKEN : KIND_NONE;
                    res_id_next   = pend_valid_reg ? pend_id_reg : '0;
                    state_next    = ST_EMIT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = ST_TCMP;
                end
            end
            ST_TCMP: begin
                if (!cmp_lt) begin
                    // Head is due: flush the previous sleeper, keep this one pending
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            m_kind_next   = KIND_WOKEN;
                            m_id_next     = pend_id_reg;
                            m_time_next   = tick_reg;
                            m_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_id;
                        head_next       = (head_reg == IW'(QUEUE_DEPTH - 1)) ? '0
                                                                             : head_reg + IW'(1);
                        occ_next        = occ_reg - CW'(1);
                        state_next      = ST_TRD;
                    end
                end else begin
                    res_kind_next = pend_valid_reg ? KIND_WOKEN : KIND_NONE;
                    res_id_next   = pend_valid_reg ? pend_id_reg : '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hand over the final result of the request
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = res_kind_reg;
                    m_id_next     = res_id_reg;
                    m_time_next   = tick_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            occ_reg        <= '0;
            head_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            occ_reg        <= occ_next;
            head_reg       <= head_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        id_reg       <= id_next;
        wake_reg     <= wake_next;
        pos_reg      <= pos_next;
        pend_id_reg  <= pend_id_next;
        res_kind_reg <= res_kind_next;
        res_id_reg   <= res_id_next;
        m_kind_reg   <= m_kind_next;
        m_id_reg     <= m_id_next;
        m_time_reg   <= m_time_next;
        m_last_reg   <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DW'({m_time_reg, m_id_reg});
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

>>> tb/sleep_queue_checker.sv
// Checker for the sleep queue: predicts results from accepted requests and compares them.
`default_nettype none

module sleep_queue_checker
    import dssq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF,
    localparam int S_DW       = ((ID_WIDTH + DUR_WIDTH + 7) / 8) * 8,
    localparam int M_DW       = ((ID_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_DW-1:0]       s_tdata,   // sleeper_id, sleep_duration
    input  wire logic                  s_tuser,   // opcode
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_DW-1:0]       m_tdata,   // woken_id, current_time
    input  wire logic [KIND_WIDTH-1:0] m_tuser,   // kind
    input  wire logic                  m_tlast,
    output int                         mismatches,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        kind_t                 kind;
        logic [ID_WIDTH-1:0]   id;
        logic [TIME_WIDTH-1:0] now;
        logic                  last;
    } wake_result_t;

    // Expected results in issue order, oldest first
    wake_result_t results_due[$];

    // Shadow copy of the sorted sleep queue and the tick counter
    logic [TIME_WIDTH-1:0] wake_at    [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]   sleeper_at [QUEUE_DEPTH];
    int                    occupied;
    logic [TIME_WIDTH-1:0] tick_now;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void queue_result(kind_t kind, logic [ID_WIDTH-1:0] id, logic last);
        wake_result_t r;
        r.kind = kind;
        r.id   = id;
        r.now  = tick_now;
        r.last = last;
        results_due.push_back(r);
    endfunction

    // Apply one request to the shadow queue and queue the results it causes
    task automatic advance_sleep_queue(input logic op, input logic [ID_WIDTH-1:0] id,
                                       input logic [DUR_WIDTH-1:0] dur);
        logic [TIME_WIDTH-1:0] wake;
        int                    pos;
        int                    n;
        if (op == OP_SLEEP) begin
            if (dur == '0 || dur[DUR_WIDTH-1]) begin
                // zero or negative duration: drop, even when full
                queue_result(KIND_IGNORED, '0, 1'b1);
            end else if (occupied >= QUEUE_DEPTH) begin
                queue_result(KIND_FULL, '0, 1'b1);
            end else begin
                wake = tick_now + TIME_WIDTH'(dur);
                // insert ahead of the first entry due at or after the new one
                pos = 0;
                while (pos < occupied && wake_at[pos] < wake)
                    pos++;
                for (int i = occupied; i > pos; i--) begin
                    wake_at[i]    = wake_at[i-1];
                    sleeper_at[i] = sleeper_at[i-1];
                end
                wake_at[pos]    = wake;
                sleeper_at[pos] = id;
                occupied++;
                queue_result(KIND_ACCEPT, '0, 1'b1);
            end
        end else begin
            tick_now = tick_now + TIME_WIDTH'(1);
            // release every entry at the head that is now due
            n = 0;
            while (n < occupied && wake_at[n] <= tick_now)
                n++;
            if (n == 0) begin
                queue_result(KIND_NONE, '0, 1'b1);
            end else begin
                for (int i = 0; i < n; i++)
                    queue_result(KIND_WOKEN, sleeper_at[i], i == n - 1);
                for (int i = n; i < occupied; i++) begin
                    wake_at[i-n]    = wake_at[i];
                    sleeper_at[i-n] = sleeper_at[i];
                end
                occupied -= n;
            end
        end
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        wake_result_t          want;
        logic [ID_WIDTH-1:0]   got_id;
        logic [TIME_WIDTH-1:0] got_now;
        got_id  = m_tdata[ID_WIDTH-1:0];
        got_now = m_tdata[ID_WIDTH +: TIME_WIDTH];
        if (results_due.size() == 0) begin
            report_mismatch($sformatf("result with none expected, kind %0d", m_tuser));
            return;
        end
        want = results_due.pop_front();
        if (m_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
        if (got_id !== want.id)
            report_mismatch($sformatf("woken_id %0d, expected %0d", got_id, want.id));
        if (got_now !== want.now)
            report_mismatch($sformatf("current_time %0d, expected %0d", got_now, want.now));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
    endtask

    // Watch both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            occupied = 0;
            tick_now = '0;
            results_due.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                advance_sleep_queue(s_tuser, s_tdata[ID_WIDTH-1:0],
                                    s_tdata[ID_WIDTH +: DUR_WIDTH]);
        end
        pending <= results_due.size();
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Top of the sleep queue testbench: clock, reset, request stimulus, result stalls and verdict.
`default_nettype none

module testbench;
    import dssq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int S_DW        = ((ID_WIDTH_DEF + DUR_WIDTH + 7) / 8) * 8;
    localparam int M_DW        = ((ID_WIDTH_DEF + TIME_WIDTH + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_REQS = 256;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DW-1:0]       s_tdata  = '0;
    logic                  s_tuser  = OP_SLEEP;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DW-1:0]       m_tdata;
    logic [KIND_WIDTH-1:0] m_tuser;
    logic                  m_tlast;
    logic                  calm     = 1'b0;
    int                    mismatches;
    int                    pending;
    int                    idle_cycles = 0;

    deadline_sorted_sleep_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sleep_queue_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 100 MHz clock
    always begin
        #5ns aclk = 1'b1;
        #5ns aclk = 1'b0;
    end

    // Stall the result channel at random, except in the calm stretch
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 22);
    end

    // End the run when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one request, with a random gap ahead of it outside the calm stretch, and hold until accepted
    task automatic send_request(input logic op, input logic [ID_WIDTH_DEF-1:0] id,
                                input logic [DUR_WIDTH-1:0] dur);
        if (!calm) begin
            while ($urandom_range(0, 99) < 22) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_DW'({dur, id});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    initial begin
        int                   i;
        int                   r;
        int                   tick_pct;
        logic [DUR_WIDTH-1:0] dur;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: tick on an empty queue, non-positive durations
        send_request(OP_TICK, ID_WIDTH_DEF'($urandom), $urandom);
        send_request(OP_SLEEP, 6'd0, 32'd0);
        send_request(OP_SLEEP, 6'd63, 32'hFFFF_FFFF);
        send_request(OP_SLEEP, 6'd5, 32'h8000_0000);
        // fill with equal wake times, one id sleeping twice
        for (i = 0; i < 16; i++)
            send_request(OP_SLEEP, (i == 15) ? 6'd63 : 6'(i * 9), 32'd2);
        // full queue: reject a valid sleep, still ignore a negative one
        send_request(OP_SLEEP, 6'd21, 32'd7);
        send_request(OP_SLEEP, 6'd22, 32'hFFFF_FFF0);
        // first tick wakes none, second releases all sixteen newest first
        send_request(OP_TICK, 6'd0, 32'd0);
        send_request(OP_TICK, 6'd63, 32'hFFFF_FFFF);
        // longest positive duration
        send_request(OP_SLEEP, 6'd42, 32'h7FFF_FFFF);

        // Random: alternate fill and drain phases
        for (i = 0; i < RANDOM_REQS; i++) begin
            if (i == 100)
                calm <= 1'b1;
            if (i == 170)
                calm <= 1'b0;
            tick_pct = ((i / 40) % 2 == 0) ? 35 : 60;
            r = $urandom_range(0, 99);
            if (r < tick_pct) begin
                send_request(OP_TICK, ID_WIDTH_DEF'($urandom), $urandom);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    dur = 32'h8000_0000 | $urandom;
                else if (r < 11)
                    dur = '0;
                else if (r < 16)
                    dur = $urandom_range(25, 300);
                else
                    dur = $urandom_range(1, 24);
                send_request(OP_SLEEP, ID_WIDTH_DEF'($urandom_range(0, 63)), dur);
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the block settle
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/dssq_pkg.sv
rtl/dssq_store.sv
rtl/deadline_sorted_sleep_queue.sv
tb/sleep_queue_checker.sv
tb/testbench.sv
